FILE: sv/plm_pkg.sv
// Package for the pulse meter hourly logger: payload structs, command codes,
// register indexes and the upload-hour reduction. No dependencies.
package plm_pkg;

	typedef enum logic {
		PLM_CMD_PULSE = 1'b0,
		PLM_CMD_TICK  = 1'b1
	} plm_cmd_t;

	localparam int unsigned PLM_CFG_IDX_W = 1;
	localparam int unsigned PLM_CFG_DATA_W = 32;

	localparam logic [PLM_CFG_IDX_W-1:0] PLM_REG_UPLOAD_HOUR = 1'b0;
	localparam logic [PLM_CFG_IDX_W-1:0] PLM_REG_START_TOTAL = 1'b1;

	localparam logic [3:0] PLM_METER_CHANNEL = 4'd5;
	localparam logic [4:0] PLM_LAST_HOUR = 5'd23;

	typedef struct packed {
		plm_cmd_t    cmd;
		logic [3:0]  source_channel;
		logic [31:0] time_stamp;
		logic [4:0]  hour_of_day;
		logic [6:0]  year_now;
		logic [3:0]  month_now;
		logic [4:0]  day_now;
	} plm_in_t;

	typedef struct packed {
		logic        pulse_counted;
		logic [4:0]  closed_hour;
		logic [15:0] hour_count;
		logic [31:0] total_count;
		logic        day_closed;
		logic [5:0]  log_index;
		logic [31:0] frozen_total;
		logic        upload_request;
		logic [4:0]  record_day;
		logic [3:0]  record_month;
		logic [6:0]  record_year;
	} plm_out_t;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
	} plm_date_t;

	// Hour value modulo 24: low three bits pass, upper five bits reduce mod 3
	// (quotient by 3 through multiply by 11 and shift by 5, exact below 32).
	function automatic logic [4:0] plm_mod24(input logic [7:0] v);
		logic [4:0] hi;
		logic [8:0] prod;
		logic [3:0] quo;
		logic [5:0] quo3;
		logic [4:0] rem;
		hi = v[7:3];
		prod = {4'b0, hi} * 9'd11;
		quo = prod[8:5];
		quo3 = {1'b0, quo, 1'b0} + {2'b0, quo};
		rem = hi - quo3[4:0];
		return {rem[1:0], v[2:0]};
	endfunction

endpackage

FILE: sv/plm_core.sv
// Logger state and single-pass update logic for one transaction.
// Depends on plm_pkg.
module plm_core #(
	parameter int unsigned LOG_DAYS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  plm_pkg::plm_in_t                    item,
	input  logic                                cfg_we,
	input  logic [plm_pkg::PLM_CFG_IDX_W-1:0]   cfg_index,
	input  logic [plm_pkg::PLM_CFG_DATA_W-1:0]  cfg_wdata,
	output plm_pkg::plm_out_t                   result
);

	logic [4:0]         upload_hour_q;
	logic [15:0]        hour_cnt_q;
	logic [31:0]        total_q;
	logic [31:0]        frozen_q;
	logic [31:0]        last_stamp_q;
	logic [5:0]         day_idx_q;
	logic               day_armed_q;
	logic               upload_armed_q;
	plm_pkg::plm_date_t date_q;

	logic [15:0]        hour_cnt_d;
	logic [31:0]        total_d;
	logic [31:0]        frozen_d;
	logic [31:0]        last_stamp_d;
	logic [5:0]         day_idx_d;
	logic               day_armed_d;
	logic               upload_armed_d;
	plm_pkg::plm_date_t date_d;
	logic               counted;
	logic               close_day;
	logic               upload;
	logic [3:0]         month_after;

	always_comb begin
		hour_cnt_d = hour_cnt_q;
		total_d = total_q;
		frozen_d = frozen_q;
		last_stamp_d = last_stamp_q;
		day_idx_d = day_idx_q;
		day_armed_d = day_armed_q;
		upload_armed_d = upload_armed_q;
		date_d = date_q;
		counted = 1'b0;
		close_day = 1'b0;
		upload = 1'b0;
		month_after = date_q.month;
		result = '0;

		if (item.cmd == plm_pkg::PLM_CMD_PULSE) begin
			counted = (item.source_channel == plm_pkg::PLM_METER_CHANNEL) &&
				(item.time_stamp != last_stamp_q);
			if (counted) begin
				total_d = total_q + 32'd1;
				hour_cnt_d = hour_cnt_q + 16'd1;
				last_stamp_d = item.time_stamp;
			end
			result.hour_count = hour_cnt_d;
		end else begin
			result.closed_hour = (item.hour_of_day == 5'd0) ?
				plm_pkg::PLM_LAST_HOUR : item.hour_of_day - 5'd1;
			result.hour_count = hour_cnt_q;
			hour_cnt_d = '0;

			close_day = (item.hour_of_day == 5'd0) && day_armed_q;
			day_armed_d = !close_day;
			if (close_day) begin
				day_idx_d = (day_idx_q == 6'(LOG_DAYS - 1)) ? 6'd0 : day_idx_q + 6'd1;
				frozen_d = total_q;
				date_d = '{year: item.year_now, month: item.month_now, day: item.day_now};
				month_after = item.month_now;
			end

			upload = (item.hour_of_day == upload_hour_q) && upload_armed_q;
			upload_armed_d = !upload;
			// On an upload, fill in the date when the log has no valid month yet
			if (upload && (month_after < 4'd1 || month_after > 4'd12)) begin
				date_d = '{year: item.year_now, month: item.month_now, day: item.day_now};
			end
		end

		result.pulse_counted = counted;
		result.total_count = total_d;
		result.day_closed = close_day;
		result.log_index = day_idx_d;
		result.frozen_total = frozen_d;
		result.upload_request = upload;
		result.record_day = date_d.day;
		result.record_month = date_d.month;
		result.record_year = date_d.year;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upload_hour_q <= '0;
			hour_cnt_q <= '0;
			total_q <= '0;
			frozen_q <= '0;
			last_stamp_q <= '0;
			day_idx_q <= '0;
			day_armed_q <= 1'b1;
			upload_armed_q <= 1'b1;
			date_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				plm_pkg::PLM_REG_UPLOAD_HOUR: begin
					upload_hour_q <= plm_pkg::plm_mod24(cfg_wdata[7:0]);
				end
				plm_pkg::PLM_REG_START_TOTAL: begin
					total_q <= cfg_wdata;
					frozen_q <= cfg_wdata;
					hour_cnt_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (fire) begin
			hour_cnt_q <= hour_cnt_d;
			total_q <= total_d;
			frozen_q <= frozen_d;
			last_stamp_q <= last_stamp_d;
			day_idx_q <= day_idx_d;
			day_armed_q <= day_armed_d;
			upload_armed_q <= upload_armed_d;
			date_q <= date_d;
		end
	end

	// Day index stays inside the ring
	assert property (@(posedge clk) disable iff (!arst_n)
		day_idx_q <= 6'(LOG_DAYS - 1))
		else $error("day index beyond ring");

	// A closed day freezes the running total
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && !cfg_we && result.day_closed |=> frozen_q == total_q)
		else $error("frozen total differs after day close");

	// Two day closes never happen on back-to-back ticks
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && !cfg_we && result.day_closed |=> !day_armed_q)
		else $error("day flag still armed after close");

endmodule

FILE: sv/pulse_meter_hourly_logger.sv
// Top level of the pulse meter hourly logger: input register, result register
// and handshake control around plm_core. Depends on plm_pkg and plm_core.
// An accepted item goes into the input register, then through plm_core into the
// result register. Throughput: one transaction per cycle while out_ready holds;
// a new item can enter the empty input register while a result waits.
// Reset (arst_n low, asynchronous): pipeline empty, counts and totals zero,
// upload hour zero, day and upload flags armed, stored date zero.
module pulse_meter_hourly_logger #(
	parameter int unsigned LOG_DAYS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  plm_pkg::plm_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output plm_pkg::plm_out_t                   out_data,
	input  logic                                cfg_we,
	input  logic [plm_pkg::PLM_CFG_IDX_W-1:0]   cfg_index,
	input  logic [plm_pkg::PLM_CFG_DATA_W-1:0]  cfg_wdata
);

	logic              valid_s1;
	plm_pkg::plm_in_t  item_s1;
	logic              valid_s2;
	plm_pkg::plm_out_t result_s2;
	plm_pkg::plm_out_t result;
	logic              advance;

	// Move stage 1 into the result register when it is free or being drained
	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_data = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	plm_core #(
		.LOG_DAYS (LOG_DAYS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item_s1),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	// An empty result register never blocks the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result register");

	// A counted pulse never reports a day close or an upload
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.pulse_counted |->
			!result_s2.day_closed && !result_s2.upload_request)
		else $error("pulse result carries tick flags");

	// A day close only comes from the hour-zero tick
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.day_closed |-> result_s2.closed_hour == plm_pkg::PLM_LAST_HOUR)
		else $error("day closed outside hour zero");

endmodule
